### src/gf256_aes_arith_unit_core_assert.svh
// Assertion macros for the GF(2^8) arithmetic unit.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef GF256_AES_ARITH_UNIT_CORE_ASSERT_SVH
`define GF256_AES_ARITH_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GFA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GFA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/gfa_pkg.sv
// Package for the GF(2^8) arithmetic unit: mode codes, sequencer states,
// field constants and the byte-wide helper functions. No dependencies.
`default_nettype none

package gfa_pkg;

  typedef enum logic [2:0] {
    MODE_ADD      = 3'd0,
    MODE_XTIME    = 3'd1,
    MODE_MUL      = 3'd2,
    MODE_INV      = 3'd3,
    MODE_SBOX     = 3'd4,
    MODE_INV_SBOX = 3'd5
  } mode_e;

  typedef enum logic {
    ST_INIT = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  localparam logic [7:0] Reduce    = 8'h1B;
  localparam logic [7:0] AffineAdd = 8'h63;
  localparam logic [7:0] AffinvAdd = 8'h05;
  localparam logic [7:0] GroupLast = 8'd254;  // last log value, order 255
  localparam logic [8:0] Order     = 9'd255;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    logic [7:0] r;
    r = {v[6:0], 1'b0};
    if (v[7]) begin
      r = r ^ Reduce;
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] v, input int unsigned n);
    logic [15:0] w;
    w = {v, v} << n;
    return w[15:8];
  endfunction

  function automatic logic [7:0] fwd_affine(input logic [7:0] v);
    return v ^ rotl(v, 1) ^ rotl(v, 2) ^ rotl(v, 3) ^ rotl(v, 4) ^ AffineAdd;
  endfunction

  function automatic logic [7:0] bwd_affine(input logic [7:0] v);
    return rotl(v, 1) ^ rotl(v, 3) ^ rotl(v, 6) ^ AffinvAdd;
  endfunction

endpackage

`default_nettype wire

### src/gf256_aes_arith_unit_core.sv
// GF(2^8) arithmetic unit over the AES field: add, xtime, multiply, inverse,
// S-box and inverse S-box, using log/exp tables held in two on-chip memories.
// Depends on gfa_pkg and gf256_aes_arith_unit_core_assert.svh.
//
// After reset the unit fills its log and exp memories by stepping through the
// powers of 3, one per cycle: busy is high while it does so and no transaction
// is taken. From then on busy stays low and a transaction can be started in
// every cycle. Each result appears on result_o, with valid_o high, for exactly
// one cycle, after passing through the log memory read and then the exp memory
// read; results come out in order and the receiver cannot hold them off. Unused
// mode codes give 0.
`default_nettype none

`include "gf256_aes_arith_unit_core_assert.svh"

module gf256_aes_arith_unit_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] mode_i,
  input  wire logic [7:0] operand_a_i,
  input  wire logic [7:0] operand_b_i,
  output logic            valid_o,
  output logic [7:0]      result_o
);

  // ---------------------------------------------------------------------------
  // Table fill sequencer
  gfa_pkg::state_e state_q, state_d;
  logic [7:0]      k_q, k_d;   // log value being written
  logic [7:0]      g_q, g_d;   // 3^k
  logic            init_we;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gfa_pkg::ST_INIT: begin
        if (k_q == gfa_pkg::GroupLast) begin
          state_d = gfa_pkg::ST_RUN;
        end
      end
      gfa_pkg::ST_RUN: begin
        state_d = gfa_pkg::ST_RUN;
      end
      default: state_d = gfa_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    init_we = 1'b0;
    busy    = 1'b1;
    unique case (state_q)
      gfa_pkg::ST_INIT: begin
        init_we = 1'b1;
        busy    = 1'b1;
      end
      gfa_pkg::ST_RUN: begin
        init_we = 1'b0;
        busy    = 1'b0;
      end
      default: begin
        init_we = 1'b0;
        busy    = 1'b1;
      end
    endcase
  end

  assign k_d = init_we ? k_q + 8'd1 : k_q;
  assign g_d = init_we ? (g_q ^ gfa_pkg::xtime(g_q)) : g_q;  // g * 3

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfa_pkg::ST_INIT;
      k_q     <= 8'd0;
      g_q     <= 8'd1;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      g_q     <= g_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: log memory read
  logic       accept;
  logic [7:0] x_in;     // operand of log lookup for b / inverse
  logic [7:0] simple_in;

  assign accept = start && !busy;
  assign x_in   = (mode_i == gfa_pkg::MODE_INV_SBOX) ? gfa_pkg::bwd_affine(operand_b_i)
                                                     : operand_b_i;
  assign simple_in = (mode_i == gfa_pkg::MODE_XTIME) ? gfa_pkg::xtime(operand_b_i)
                                                     : (operand_a_i ^ operand_b_i);

  logic [7:0] log_mem [256];
  logic [7:0] la_q, lx_q;

  always_ff @(posedge clk_i) begin
    if (init_we) begin
      log_mem[g_q] <= k_q;
    end
    la_q <= log_mem[operand_a_i];
    lx_q <= log_mem[x_in];
  end

  logic       v1_q;
  logic [2:0] mode1_q;
  logic       za1_q, zx1_q;
  logic [7:0] simple1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    mode1_q   <= mode_i;
    za1_q     <= (operand_a_i == 8'd0);
    zx1_q     <= (x_in == 8'd0);
    simple1_q <= simple_in;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: exponent arithmetic and exp memory read
  logic [8:0] log_sum;
  logic [7:0] log_mul, log_inv, exp_addr;

  assign log_sum = {1'b0, la_q} + {1'b0, lx_q};
  assign log_mul = (log_sum >= gfa_pkg::Order) ? 8'(log_sum - gfa_pkg::Order)
                                               : log_sum[7:0];
  assign log_inv = (lx_q == 8'd0) ? 8'd0 : 8'(gfa_pkg::Order - {1'b0, lx_q});
  assign exp_addr = (mode1_q == gfa_pkg::MODE_MUL) ? log_mul : log_inv;

  logic [7:0] exp_mem [255];
  logic [7:0] exp_q;

  always_ff @(posedge clk_i) begin
    if (init_we) begin
      exp_mem[k_q] <= g_q;
    end
    exp_q <= exp_mem[exp_addr];
  end

  logic       v2_q;
  logic [2:0] mode2_q;
  logic       zp2_q, zx2_q;
  logic [7:0] simple2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mode2_q   <= mode1_q;
    zp2_q     <= za1_q || zx1_q;
    zx2_q     <= zx1_q;
    simple2_q <= simple1_q;
  end

  // ---------------------------------------------------------------------------
  // Result select
  logic [7:0] inv_val;

  assign inv_val = zx2_q ? 8'd0 : exp_q;  // inverse of zero taken as zero

  always_comb begin
    case (mode2_q)
      gfa_pkg::MODE_ADD, gfa_pkg::MODE_XTIME: result_o = simple2_q;
      gfa_pkg::MODE_MUL:                      result_o = zp2_q ? 8'd0 : exp_q;
      gfa_pkg::MODE_INV:                      result_o = inv_val;
      gfa_pkg::MODE_SBOX:                     result_o = gfa_pkg::fwd_affine(inv_val);
      gfa_pkg::MODE_INV_SBOX:                 result_o = inv_val;
      default:                                result_o = 8'd0;
    endcase
  end

  assign valid_o = v2_q;

  // ---------------------------------------------------------------------------
  // Assertions
  `GFA_ASSERT_IMP(a_no_work_in_init, state_q == gfa_pkg::ST_INIT, !v1_q && !v2_q,
                  "pipeline active while tables are being filled")
  `GFA_ASSERT_NXT(a_accept_enters, start && !busy, v1_q,
                  "accepted transaction missing from stage 1")
  `GFA_ASSERT_NXT(a_stage_to_out, v1_q, valid_o,
                  "stage 1 transaction not delivered")
  `GFA_ASSERT_IMP(a_sbox_zero, valid_o && mode2_q == gfa_pkg::MODE_SBOX && zx2_q,
                  result_o == gfa_pkg::AffineAdd, "S-box of zero is not 0x63")
  `GFA_ASSERT_NXT(a_init_done, state_q == gfa_pkg::ST_INIT && k_q == gfa_pkg::GroupLast,
                  state_q == gfa_pkg::ST_RUN && !busy, "table fill did not finish")

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for gf256_aes_arith_unit_core: random and directed field operations,
// with results predicted locally. Depends on gfa_pkg (mode codes, field constants).
module tb;

  localparam int          CLK_HALF    = 5;
  localparam int          RST_CYCLES  = 7;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          MAX_REPORTS = 10;
  localparam int          PER_PHASE   = 460;
  localparam int          DRAIN_WAIT  = 8;
  // codes outside the package enum; the unit must give zero for them
  localparam logic [2:0]  MODE_RSVD6  = 3'd6;
  localparam logic [2:0]  MODE_RSVD7  = 3'd7;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] a;
    logic [7:0] b;
  } gf_op_t;

  typedef struct packed {
    gf_op_t     op;
    logic [7:0] res;
  } gf_res_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic [2:0] mode_i      = '0;
  logic [7:0] operand_a_i = '0;
  logic [7:0] operand_b_i = '0;
  logic       busy;
  logic       valid_o;
  logic [7:0] result_o;

  gf_op_t  op_q[$];
  gf_res_t result_q[$];
  int      idle_pct = 0;
  int      n_errors = 0;
  int      n_cycles = 0;

  gf256_aes_arith_unit_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (valid_o),
    .result_o    (result_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // ---------------- field arithmetic ----------------
  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    return v[7] ? ((v << 1) ^ gfa_pkg::Reduce) : (v << 1);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (x[k]) acc = acc ^ y;
      y = gf_dbl(y);
    end
    return acc;
  endfunction

  // x^254, which is 0 for x = 0
  function automatic logic [7:0] gf_recip(input logic [7:0] x);
    logic [7:0] acc;
    logic [7:0] sq;
    logic [7:0] e;
    acc = 8'h01;
    sq  = x;
    e   = 8'd254;
    for (int k = 0; k < 8; k++) begin
      if (e[k]) acc = gf_mul(acc, sq);
      sq = gf_mul(sq, sq);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
    logic [7:0] r;
    r = v;
    for (int k = 0; k < n; k++) r = {r[6:0], r[7]};
    return r;
  endfunction

  function automatic logic [7:0] predict_byte(input gf_op_t op);
    logic [7:0] r;
    case (op.mode)
      gfa_pkg::MODE_ADD:      r = op.a ^ op.b;
      gfa_pkg::MODE_XTIME:    r = gf_dbl(op.b);
      gfa_pkg::MODE_MUL:      r = gf_mul(op.a, op.b);
      gfa_pkg::MODE_INV:      r = gf_recip(op.b);
      gfa_pkg::MODE_SBOX: begin
        r = gf_recip(op.b);
        r = r ^ rol8(r, 1) ^ rol8(r, 2) ^ rol8(r, 3) ^ rol8(r, 4) ^ gfa_pkg::AffineAdd;
      end
      gfa_pkg::MODE_INV_SBOX: begin
        r = rol8(op.b, 1) ^ rol8(op.b, 3) ^ rol8(op.b, 6) ^ gfa_pkg::AffinvAdd;
        r = gf_recip(r);
      end
      default:       r = '0;
    endcase
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_mode();
    case ($urandom_range(0, 99))
      0:       return MODE_RSVD6;
      1:       return MODE_RSVD7;
      default: return 3'($urandom_range(gfa_pkg::MODE_ADD, gfa_pkg::MODE_INV_SBOX));
    endcase
  endfunction

  task automatic queue_op(input logic [2:0] m, input logic [7:0] a, input logic [7:0] b);
    gf_op_t op;
    op.mode = m;
    op.a    = a;
    op.b    = b;
    op_q = {op_q, op};
  endtask

  // ---------------- driver ----------------
  always @(posedge clk_i) begin : drv
    gf_op_t cur;
    gf_op_t nxt;
    gf_res_t exp_r;
    if (rst_ni) begin
      cur.mode = mode_i;
      cur.a    = operand_a_i;
      cur.b    = operand_b_i;
      if (start && !busy) begin
        exp_r.op  = cur;
        exp_r.res = predict_byte(cur);
        result_q = {result_q, exp_r};
      end
      // a held request stays up until the unit takes it
      if (!start || !busy) begin
        if (op_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt         = op_q.pop_front();
          mode_i      <= nxt.mode;
          operand_a_i <= nxt.a;
          operand_b_i <= nxt.b;
          start       <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin : mon
    gf_res_t exp_r;
    if (rst_ni && valid_o) begin
      if (result_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("unexpected result %02h with no transaction outstanding", result_o);
      end else begin
        exp_r = result_q.pop_front();
        if (result_o !== exp_r.res) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("mismatch: mode %0d a %02h b %02h expected %02h got %02h",
                     exp_r.op.mode, exp_r.op.a, exp_r.op.b, exp_r.res, result_o);
        end
      end
    end
  end

  // ---------------- timeout ----------------
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin : seq
    int phase_idle[4];
    phase_idle = '{0, 45, 0, 23};

    // directed: operand extremes, every mode, zero cases, unused codes
    queue_op(gfa_pkg::MODE_ADD,      8'h00, 8'h00);
    queue_op(gfa_pkg::MODE_ADD,      8'hFF, 8'hFF);
    queue_op(gfa_pkg::MODE_ADD,      8'h55, 8'hAA);
    queue_op(gfa_pkg::MODE_XTIME,    8'hFF, 8'h80);
    queue_op(gfa_pkg::MODE_XTIME,    8'h00, 8'h7F);
    queue_op(gfa_pkg::MODE_XTIME,    8'hAA, 8'hFF);
    queue_op(gfa_pkg::MODE_XTIME,    8'h55, 8'h00);
    queue_op(gfa_pkg::MODE_MUL,      8'h00, 8'h9C);
    queue_op(gfa_pkg::MODE_MUL,      8'hD3, 8'h00);
    queue_op(gfa_pkg::MODE_MUL,      8'hFF, 8'hFF);
    queue_op(gfa_pkg::MODE_MUL,      8'h57, 8'h83);
    queue_op(gfa_pkg::MODE_MUL,      8'h01, 8'hAB);
    queue_op(gfa_pkg::MODE_INV,      8'hFF, 8'h00);
    queue_op(gfa_pkg::MODE_INV,      8'h00, 8'h01);
    queue_op(gfa_pkg::MODE_INV,      8'h12, 8'hFF);
    queue_op(gfa_pkg::MODE_SBOX,     8'h00, 8'h00);
    queue_op(gfa_pkg::MODE_SBOX,     8'hFF, 8'hFF);
    queue_op(gfa_pkg::MODE_SBOX,     8'h00, 8'h53);
    queue_op(gfa_pkg::MODE_INV_SBOX, 8'h00, 8'h63);
    queue_op(gfa_pkg::MODE_INV_SBOX, 8'hFF, 8'h00);
    queue_op(gfa_pkg::MODE_INV_SBOX, 8'h00, 8'hFF);
    queue_op(MODE_RSVD6,             8'hFF, 8'hFF);
    queue_op(MODE_RSVD7,             8'hFF, 8'hFF);
    queue_op(MODE_RSVD7,             8'h00, 8'h00);

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      for (int i = 0; i < PER_PHASE; i++)
        queue_op(pick_mode(), pick_byte(), pick_byte());
      while (op_q.size() != 0) @(posedge clk_i);
    end

    while (start || result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/gfa_pkg.sv
src/gf256_aes_arith_unit_core.sv
bench/tb.sv
